// ----- design/tlvx_pkg.sv -----
// Shared types and constants for the request TLV field extractor.
// No dependencies; used by tlvx_parser and request_tlv_field_extractor.
package tlvx_pkg;

   localparam logic [15:0] TYPE_AMOUNT = 16'd82;
   localparam logic [15:0] LEN_AMOUNT  = 16'd8;
   localparam logic [15:0] TYPE_KEY    = 16'd88;
   localparam logic [15:0] LEN_KEY     = 16'd33;
   localparam logic [15:0] TYPE_SIG    = 16'd240;
   localparam logic [15:0] LEN_SIG     = 16'd64;

   localparam logic [2:0]  HDR_BYTES   = 3'd4;

   localparam int RSP_DATA_W = 80;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_SIG    = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  byte_index;
      logic [7:0]  out_byte;
      logic        record_complete;
      logic [63:0] amount;
      logic        request_ok;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic    byte_vld;
      rsp_type byte_rsp;
      logic    stat_vld;
      rsp_type stat_rsp;
   } parse_out_type;

endpackage

// ----- design/request_tlv_field_extractor.sv -----
// Top level of the request TLV field extractor: parser plus result queue.
// Depends on tlvx_pkg and tlvx_parser.
//
// Takes one stream byte per beat and accepts a new byte in every cycle while
// the queue has room for two beats. Each byte is parsed in the cycle it is
// accepted; key and signature value bytes produce one result beat each, and
// the byte flagged tlast adds a status beat carrying the committed amount and
// the ok bit. Results wait in a four-entry queue that drains one beat per
// cycle while rsp_tready is high; a byte's results are registered into the
// queue when the byte is accepted. The sustained rate is one byte per cycle,
// limited by the single-beat result port when a final byte produces two
// beats. req_tready drops only when the queue lacks room for two beats.
module request_tlv_field_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [5:0] byte_index, [13:6] out_byte,
                                    // [14] record_complete, [78:15] amount,
                                    // [79] request_ok
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_result
);

   tlvx_pkg::parse_out_type parse_out;
   tlvx_pkg::rsp_type       queue_ff [tlvx_pkg::QUEUE_DEPTH];
   tlvx_pkg::rsp_type       head;

   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff,  count_in;
   logic [1:0] stat_ptr;
   logic       req_accept, rsp_accept;
   logic       push_byte,  push_stat;

   assign req_tready = (count_ff <= 3'd2);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_accept = rsp_tvalid & rsp_tready;

   tlvx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .parse_out (parse_out)
   );

   assign push_byte = req_accept & parse_out.byte_vld;
   assign push_stat = req_accept & parse_out.stat_vld;
   assign stat_ptr  = wr_ptr_ff + {1'b0, push_byte};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push_byte} + {1'b0, push_stat};
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_accept};
      count_in  = count_ff + {2'b00, push_byte} + {2'b00, push_stat} - {2'b00, rsp_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_byte) begin
         queue_ff[wr_ptr_ff] <= parse_out.byte_rsp;
      end
      if (push_stat) begin
         queue_ff[stat_ptr] <= parse_out.stat_rsp;
      end
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {head.request_ok, head.amount, head.record_complete,
                       head.out_byte, head.byte_index};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_result;

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tlvx_pkg::KIND_STATUS)) |-> rsp_tlast)
      else $error("status beat without tlast");

   a_last_queues : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (count_ff != 3'd0))
      else $error("final byte did not queue a status beat");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])
      else $error("queue pointers disagree with count");

endmodule

// ----- design/tlvx_parser.sv -----
// Record header/value tracker for the TLV field extractor.
// Depends on tlvx_pkg; produces up to two results per accepted byte.
module tlvx_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output tlvx_pkg::parse_out_type parse_out
);

   logic [2:0]  hdr_cnt_ff,   hdr_cnt_in;
   logic [15:0] rec_type_ff,  rec_type_in;
   logic [15:0] rec_len_ff,   rec_len_in;
   logic [15:0] val_cnt_ff,   val_cnt_in;
   logic [63:0] amt_pend_ff,  amt_pend_in;
   logic [63:0] amt_comm_ff,  amt_comm_in;
   logic        key_seen_ff,  key_seen_in;
   logic        sig_seen_ff,  sig_seen_in;

   logic        done;
   logic        is_amount, is_key, is_sig;

   assign is_amount = (rec_type_ff == tlvx_pkg::TYPE_AMOUNT) && (rec_len_ff == tlvx_pkg::LEN_AMOUNT);
   assign is_key    = (rec_type_ff == tlvx_pkg::TYPE_KEY)    && (rec_len_ff == tlvx_pkg::LEN_KEY);
   assign is_sig    = (rec_type_ff == tlvx_pkg::TYPE_SIG)    && (rec_len_ff == tlvx_pkg::LEN_SIG);

   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      rec_type_in = rec_type_ff;
      rec_len_in  = rec_len_ff;
      val_cnt_in  = val_cnt_ff;
      amt_pend_in = amt_pend_ff;
      amt_comm_in = amt_comm_ff;
      key_seen_in = key_seen_ff;
      sig_seen_in = sig_seen_ff;
      done        = 1'b0;

      parse_out.byte_vld                 = 1'b0;
      parse_out.byte_rsp.kind            = tlvx_pkg::KIND_KEY;
      parse_out.byte_rsp.byte_index      = val_cnt_ff[5:0];
      parse_out.byte_rsp.out_byte        = in_byte;
      parse_out.byte_rsp.record_complete = 1'b0;
      parse_out.byte_rsp.amount          = 64'd0;
      parse_out.byte_rsp.request_ok      = 1'b0;
      parse_out.byte_rsp.last_result     = ~in_last;

      if (hdr_cnt_ff < tlvx_pkg::HDR_BYTES) begin
         if (hdr_cnt_ff < 3'd2) begin
            rec_type_in = {rec_type_ff[7:0], in_byte};
         end else begin
            rec_len_in = {rec_len_ff[7:0], in_byte};
         end
         hdr_cnt_in = hdr_cnt_ff + 3'd1;
         if (hdr_cnt_in == tlvx_pkg::HDR_BYTES) begin
            val_cnt_in  = 16'd0;
            amt_pend_in = 64'd0;
            // zero-length record ends with its header
            if (rec_len_in == 16'd0) begin
               hdr_cnt_in = 3'd0;
            end
         end
      end else begin
         val_cnt_in = val_cnt_ff + 16'd1;
         done       = (val_cnt_in == rec_len_ff);
         parse_out.byte_rsp.record_complete = done;
         if (is_amount) begin
            amt_pend_in = {amt_pend_ff[55:0], in_byte};
            if (done) begin
               amt_comm_in = amt_pend_in;
            end
         end else if (is_key) begin
            parse_out.byte_vld = 1'b1;
            if (done) begin
               key_seen_in = 1'b1;
            end
         end else if (is_sig) begin
            parse_out.byte_vld      = 1'b1;
            parse_out.byte_rsp.kind = tlvx_pkg::KIND_SIG;
            if (done) begin
               sig_seen_in = 1'b1;
            end
         end
         if (done) begin
            hdr_cnt_in = 3'd0;
         end
      end

      parse_out.stat_vld                 = in_last;
      parse_out.stat_rsp.kind            = tlvx_pkg::KIND_STATUS;
      parse_out.stat_rsp.byte_index      = 6'd0;
      parse_out.stat_rsp.out_byte        = 8'd0;
      parse_out.stat_rsp.record_complete = 1'b0;
      parse_out.stat_rsp.amount          = amt_comm_in;
      parse_out.stat_rsp.request_ok      = key_seen_in & sig_seen_in;
      parse_out.stat_rsp.last_result     = 1'b1;

      // end of stream: back to a clean parser
      if (in_last) begin
         hdr_cnt_in  = 3'd0;
         rec_type_in = 16'd0;
         rec_len_in  = 16'd0;
         val_cnt_in  = 16'd0;
         amt_pend_in = 64'd0;
         amt_comm_in = 64'd0;
         key_seen_in = 1'b0;
         sig_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= 3'd0;
         rec_type_ff <= 16'd0;
         rec_len_ff  <= 16'd0;
         val_cnt_ff  <= 16'd0;
         amt_pend_ff <= 64'd0;
         amt_comm_ff <= 64'd0;
         key_seen_ff <= 1'b0;
         sig_seen_ff <= 1'b0;
      end else if (accept) begin
         hdr_cnt_ff  <= hdr_cnt_in;
         rec_type_ff <= rec_type_in;
         rec_len_ff  <= rec_len_in;
         val_cnt_ff  <= val_cnt_in;
         amt_pend_ff <= amt_pend_in;
         amt_comm_ff <= amt_comm_in;
         key_seen_ff <= key_seen_in;
         sig_seen_ff <= sig_seen_in;
      end
   end

endmodule

// ----- test/request_tlv_field_extractor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for request_tlv_field_extractor: record streams in, key, signature
// and status beats out, each compared with a beat-accurate parser predictor.
// Depends on tlvx_pkg and the design sources.
module request_tlv_field_extractor_tb;

   typedef struct {
      logic [7:0] data;
      logic       tlast;
      logic       drain;   // hold this beat until every expected result is out
   } stream_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   request_tlv_field_extractor uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // parser shadow state
   logic [2:0]  hdr_cnt = '0;
   logic [15:0] rec_type = '0;
   logic [15:0] rec_len = '0;
   logic [15:0] val_cnt = '0;
   logic [63:0] amt_pend = '0;
   logic [63:0] amt_commit = '0;
   logic        key_seen = 1'b0;
   logic        sig_seen = 1'b0;

   stream_beat_type   pend_q[$];
   tlvx_pkg::rsp_type expected_rsp_q[$];
   stream_beat_type   cur_beat;
   tlvx_pkg::rsp_type got_rsp;
   tlvx_pkg::rsp_type want_rsp;

   int  total_beats = 0;
   int  stream_cnt = 0;
   int  accepted_cnt = 0;
   int  sent_cnt = 0;
   int  rsp_seen = 0;
   int  status_seen = 0;
   int  err_cnt = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_at = 60;
   bit  no_idle = 1'b0;
   logic req_fire = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 92) return $urandom_range(3, 1);
      if (p < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic log_error(input string msg);
      err_cnt++;
      if (err_cnt <= 10) $display("%s", msg);
   endtask

   task automatic clear_parser();
      hdr_cnt = '0;
      rec_type = '0;
      rec_len = '0;
      val_cnt = '0;
      amt_pend = '0;
      amt_commit = '0;
      key_seen = 1'b0;
      sig_seen = 1'b0;
   endtask

   task automatic parse_stream_byte(input logic [7:0] b, input logic is_final);
      tlvx_pkg::rsp_type r;
      logic [15:0]       idx;
      logic              done;
      if (hdr_cnt < tlvx_pkg::HDR_BYTES) begin
         if (hdr_cnt < 3'd2) rec_type = {rec_type[7:0], b};
         else rec_len = {rec_len[7:0], b};
         hdr_cnt = hdr_cnt + 3'd1;
         if (hdr_cnt == tlvx_pkg::HDR_BYTES) begin
            val_cnt = '0;
            amt_pend = '0;
            // a zero-length record ends with its header
            if (rec_len == 16'd0) hdr_cnt = '0;
         end
      end else begin
         idx = val_cnt;
         val_cnt = val_cnt + 16'd1;
         done = (val_cnt == rec_len);
         r = '0;
         r.byte_index = idx[5:0];
         r.out_byte = b;
         r.record_complete = done;
         r.last_result = !is_final;
         if (rec_type == tlvx_pkg::TYPE_AMOUNT && rec_len == tlvx_pkg::LEN_AMOUNT) begin
            amt_pend = {amt_pend[55:0], b};
            if (done) amt_commit = amt_pend;
         end else if (rec_type == tlvx_pkg::TYPE_KEY && rec_len == tlvx_pkg::LEN_KEY) begin
            r.kind = tlvx_pkg::KIND_KEY;
            expected_rsp_q.push_back(r);
            if (done) key_seen = 1'b1;
         end else if (rec_type == tlvx_pkg::TYPE_SIG && rec_len == tlvx_pkg::LEN_SIG) begin
            r.kind = tlvx_pkg::KIND_SIG;
            expected_rsp_q.push_back(r);
            if (done) sig_seen = 1'b1;
         end
         if (done) hdr_cnt = '0;
      end
      if (is_final) begin
         r = '0;
         r.kind = tlvx_pkg::KIND_STATUS;
         r.amount = amt_commit;
         r.request_ok = key_seen & sig_seen;
         r.last_result = 1'b1;
         expected_rsp_q.push_back(r);
         clear_parser();
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      pend_q.push_back('{data: b, tlast: 1'b0, drain: 1'b0});
   endtask

   task automatic push_record(input logic [15:0] typ, input logic [15:0] len, input int nval);
      int         fill;
      int         k;
      logic [7:0] b;
      fill = $urandom_range(5);
      push_byte(typ[15:8]);
      push_byte(typ[7:0]);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      for (k = 0; k < nval; k++) begin
         b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(255));
         push_byte(b);
      end
   endtask

   // flag the final byte of the stream; never leave a stream empty
   task automatic close_stream(input int start, input bit drain);
      if (pend_q.size() == start) push_byte(8'($urandom_range(255)));
      pend_q[pend_q.size() - 1].tlast = 1'b1;
      if (drain) pend_q[start].drain = 1'b1;
      stream_cnt++;
   endtask

   task automatic add_random_stream(input bit drain);
      int          start;
      int          nrec;
      int          k;
      int          pick;
      logic [15:0] len;
      logic [15:0] typ;
      start = pend_q.size();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(24, 1)) push_byte(8'($urandom_range(255)));
      end else begin
         nrec = $urandom_range(5);
         for (k = 0; k < nrec; k++) begin
            pick = $urandom_range(11);
            case (pick)
               0, 1, 2: push_record(tlvx_pkg::TYPE_KEY, tlvx_pkg::LEN_KEY, tlvx_pkg::LEN_KEY);
               3, 4, 5: push_record(tlvx_pkg::TYPE_SIG, tlvx_pkg::LEN_SIG, tlvx_pkg::LEN_SIG);
               6, 7: push_record(tlvx_pkg::TYPE_AMOUNT, tlvx_pkg::LEN_AMOUNT,
                                 tlvx_pkg::LEN_AMOUNT);
               8: begin
                  len = 16'($urandom_range(6));
                  push_record(16'($urandom), len, len);
               end
               9: begin
                  // right type, wrong length, or a stray high type byte
                  case ($urandom_range(3))
                     0: push_record(tlvx_pkg::TYPE_KEY, tlvx_pkg::LEN_KEY - 16'd1,
                                    tlvx_pkg::LEN_KEY - 16'd1);
                     1: push_record(tlvx_pkg::TYPE_SIG, tlvx_pkg::LEN_SIG + 16'd1,
                                    tlvx_pkg::LEN_SIG + 16'd1);
                     2: push_record(tlvx_pkg::TYPE_AMOUNT, tlvx_pkg::LEN_AMOUNT - 16'd1,
                                    tlvx_pkg::LEN_AMOUNT - 16'd1);
                     default: push_record(tlvx_pkg::TYPE_KEY | 16'h0100, tlvx_pkg::LEN_KEY,
                                          tlvx_pkg::LEN_KEY);
                  endcase
               end
               10: begin
                  typ = ($urandom_range(1) == 0) ? tlvx_pkg::TYPE_SIG : 16'($urandom);
                  push_record(typ, 16'd0, 0);
               end
               default: begin
                  len = 16'($urandom_range(40));
                  push_record(16'($urandom), len, len);
               end
            endcase
         end
         pick = $urandom_range(9);
         if (pick < 2) begin
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
         end else if (pick < 4) begin
            // cut a record short at the end of the stream
            case ($urandom_range(3))
               0: push_record(tlvx_pkg::TYPE_KEY, tlvx_pkg::LEN_KEY,
                              $urandom_range(tlvx_pkg::LEN_KEY - 1));
               1: push_record(tlvx_pkg::TYPE_SIG, tlvx_pkg::LEN_SIG,
                              $urandom_range(tlvx_pkg::LEN_SIG - 1));
               2: push_record(tlvx_pkg::TYPE_AMOUNT, tlvx_pkg::LEN_AMOUNT,
                              $urandom_range(tlvx_pkg::LEN_AMOUNT - 1));
               default: push_record(16'($urandom), 16'($urandom_range(65535, 6)),
                                    $urandom_range(5));
            endcase
         end
      end
      close_stream(start, drain || ($urandom_range(9) == 0));
   endtask

   task automatic build_stimulus();
      int start;
      // lone byte: a partial header only
      start = pend_q.size();
      push_byte(8'hFF);
      close_stream(start, 1'b0);
      // zero-length key record, all-ones amount, then a dangling header
      start = pend_q.size();
      push_record(tlvx_pkg::TYPE_KEY, 16'd0, 0);
      push_byte(tlvx_pkg::TYPE_AMOUNT[15:8]);
      push_byte(tlvx_pkg::TYPE_AMOUNT[7:0]);
      push_byte(tlvx_pkg::LEN_AMOUNT[15:8]);
      push_byte(tlvx_pkg::LEN_AMOUNT[7:0]);
      repeat (8) push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h00);
      close_stream(start, 1'b0);
      // key record cut after its first value byte
      start = pend_q.size();
      push_byte(tlvx_pkg::TYPE_KEY[15:8]);
      push_byte(tlvx_pkg::TYPE_KEY[7:0]);
      push_byte(tlvx_pkg::LEN_KEY[15:8]);
      push_byte(tlvx_pkg::LEN_KEY[7:0]);
      push_byte(8'h5A);
      close_stream(start, 1'b0);
      add_random_stream(1'b1);
      while (pend_q.size() < 2000) add_random_stream(1'b0);
      total_beats = pend_q.size();
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pend_q.size() > 0 &&
                      !(pend_q[0].drain && expected_rsp_q.size() != 0)) begin
            cur_beat = pend_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= cur_beat.data;
            req_tlast <= cur_beat.tlast;
            sent_cnt++;
            no_idle = (sent_cnt % 300) < 60;
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_seen >= hold_at) begin
         hold_left = 200;
         hold_at = hold_at + 900;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // predict on accepted bytes, check every accepted result beat
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            parse_stream_byte(req_tdata, req_tlast);
            accepted_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.kind = tlvx_pkg::kind_type'(rsp_tuser);
            got_rsp.byte_index = rsp_tdata[5:0];
            got_rsp.out_byte = rsp_tdata[13:6];
            got_rsp.record_complete = rsp_tdata[14];
            got_rsp.amount = rsp_tdata[78:15];
            got_rsp.request_ok = rsp_tdata[79];
            got_rsp.last_result = rsp_tlast;
            if (expected_rsp_q.size() == 0) begin
               log_error($sformatf("unexpected result beat %0d: kind=%0d idx=%0d byte=%02h",
                                   rsp_seen, got_rsp.kind, got_rsp.byte_index,
                                   got_rsp.out_byte));
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               if (got_rsp.kind !== want_rsp.kind ||
                   got_rsp.byte_index !== want_rsp.byte_index ||
                   got_rsp.out_byte !== want_rsp.out_byte ||
                   got_rsp.record_complete !== want_rsp.record_complete ||
                   got_rsp.amount !== want_rsp.amount ||
                   got_rsp.request_ok !== want_rsp.request_ok ||
                   got_rsp.last_result !== want_rsp.last_result) begin
                  log_error($sformatf({"mismatch on result beat %0d:\n",
                     "  exp kind=%0d idx=%0d byte=%02h done=%0b amt=%016h ok=%0b last=%0b\n",
                     "  got kind=%0d idx=%0d byte=%02h done=%0b amt=%016h ok=%0b last=%0b"},
                     rsp_seen, want_rsp.kind, want_rsp.byte_index, want_rsp.out_byte,
                     want_rsp.record_complete, want_rsp.amount, want_rsp.request_ok,
                     want_rsp.last_result, got_rsp.kind, got_rsp.byte_index,
                     got_rsp.out_byte, got_rsp.record_complete, got_rsp.amount,
                     got_rsp.request_ok, got_rsp.last_result));
               end
            end
            if (got_rsp.kind == tlvx_pkg::KIND_STATUS) status_seen++;
            rsp_seen++;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      while (accepted_cnt < total_beats) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Streamed %0d bytes in %0d record streams with stalls on both sides,",
               total_beats, stream_cnt);
      $display("checked %0d result beats, %0d of them status.", rsp_seen, status_seen);
      if (err_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("%0d errors", err_cnt);
         $display("FAIL");
      end
      $finish;
   end

endmodule
